>>> design/biq_pkg.sv
// Shared types, constants and control word layout for the biquad filter.
package biq_pkg;

    localparam int SampleW   = 16;
    localparam int CoefW     = 18;
    localparam int StateFrac = 16;
    localparam int DelayW    = 40;
    localparam int SplitW    = 20;                  // low half of a delay word
    localparam int OpndW     = DelayW - SplitW + 1; // signed multiplier operand
    localparam int ProdW     = CoefW + OpndW;
    localparam int AccW      = CoefW + DelayW;
    localparam int FW        = DelayW + 2;          // holds -2*y
    localparam int WideW     = FW + 3;
    localparam int StepW     = 5;
    localparam int RegIdxW   = 3;
    localparam int AddrW     = RegIdxW + 2;
    localparam int DataW     = 32;

    typedef logic signed [SampleW-1:0] sample_t;
    typedef logic signed [CoefW-1:0]   coef_t;
    typedef logic signed [DelayW-1:0]  delay_t;
    typedef logic signed [OpndW-1:0]   opnd_t;
    typedef logic signed [ProdW-1:0]   prod_t;
    typedef logic signed [AccW-1:0]    acc_t;
    typedef logic signed [FW-1:0]      fval_t;
    typedef logic signed [WideW-1:0]   wide_t;
    typedef logic [StepW-1:0]          step_t;

    localparam coef_t B0Reset  = 18'sd5984;
    localparam coef_t B1Reset  = 18'sd11969;
    localparam coef_t B2Reset  = 18'sd5984;
    localparam coef_t A1Reset  = -18'sd64384;
    localparam coef_t A2Reset  = 18'sd22785;
    localparam coef_t SA1Reset = -18'sd108869;
    localparam coef_t SA2Reset = 18'sd53364;

    localparam step_t StepEmit = 5'd16;

    typedef enum logic [RegIdxW-1:0] {
        REG_MODE, REG_B0, REG_B1, REG_B2, REG_A1, REG_A2, REG_SA1, REG_SA2
    } reg_idx_t;

    typedef enum logic [2:0] {
        CSEL_B0, CSEL_B1, CSEL_B2, CSEL_A1, CSEL_A2, CSEL_SA1, CSEL_SA2
    } coef_sel_t;

    typedef enum logic [1:0] {
        OPND_SAMPLE, OPND_YLO, OPND_YHI
    } opnd_sel_t;

    typedef enum logic [2:0] {
        F_NOP, F_LD0, F_LD1, F_LD2, F_LDY
    } f_op_t;

    typedef enum logic [1:0] {
        ACC_NOP, ACC_LOAD, ACC_ADDHI
    } acc_op_t;

    typedef enum logic [1:0] {
        ALU_NOP, ALU_Y, ALU_D1, ALU_D2
    } alu_op_t;

    typedef enum logic [1:0] {
        SEQ_NEXT, SEQ_SKIP_SINGLE, SEQ_EMIT
    } seq_op_t;

    typedef struct packed {
        logic      mul_en;
        coef_sel_t coef_sel;
        opnd_sel_t opnd_sel;
        f_op_t     f_op;
        acc_op_t   acc_op;
        alu_op_t   alu_op;
        logic      sec;       // 0 first section delays, 1 second
        seq_op_t   seq_op;
        step_t     target;
    } ctrl_t;

    localparam ctrl_t NopCtrl = '{
        mul_en:   1'b0,
        coef_sel: CSEL_B0,
        opnd_sel: OPND_SAMPLE,
        f_op:     F_NOP,
        acc_op:   ACC_NOP,
        alu_op:   ALU_NOP,
        sec:      1'b0,
        seq_op:   SEQ_NEXT,
        target:   '0
    };

    typedef struct packed {
        logic run;
        logic load;
        logic emit;
    } seq_t;

    typedef struct packed {
        logic  mode;
        coef_t b0;
        coef_t b1;
        coef_t b2;
        coef_t a1;
        coef_t a2;
        coef_t sa1;
        coef_t sa2;
    } cfg_t;

endpackage

>>> design/biq_cfg.sv
// APB-style register bank holding the mode bit and filter coefficients.
module biq_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [biq_pkg::AddrW-1:0]    paddr,
    input  logic [biq_pkg::DataW-1:0]    pwdata,
    output logic [biq_pkg::DataW-1:0]    prdata,
    output logic                         pready,
    output biq_pkg::cfg_t                cfg
);

    biq_pkg::cfg_t     cfg_reg;
    biq_pkg::cfg_t     cfg_next;
    biq_pkg::reg_idx_t idx;
    biq_pkg::coef_t    wcoef;
    logic              wr_en;

    assign pready = 1'b1;
    assign idx    = biq_pkg::reg_idx_t'(paddr[biq_pkg::AddrW-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign wcoef  = biq_pkg::coef_t'(pwdata[biq_pkg::CoefW-1:0]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                biq_pkg::REG_MODE: cfg_next.mode = pwdata[0];
                biq_pkg::REG_B0:   cfg_next.b0   = wcoef;
                biq_pkg::REG_B1:   cfg_next.b1   = wcoef;
                biq_pkg::REG_B2:   cfg_next.b2   = wcoef;
                biq_pkg::REG_A1:   cfg_next.a1   = wcoef;
                biq_pkg::REG_A2:   cfg_next.a2   = wcoef;
                biq_pkg::REG_SA1:  cfg_next.sa1  = wcoef;
                biq_pkg::REG_SA2:  cfg_next.sa2  = wcoef;
                default:           cfg_next      = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            biq_pkg::REG_MODE: prdata = {{(biq_pkg::DataW-1){1'b0}}, cfg_reg.mode};
            biq_pkg::REG_B0:   prdata = biq_pkg::DataW'(cfg_reg.b0);
            biq_pkg::REG_B1:   prdata = biq_pkg::DataW'(cfg_reg.b1);
            biq_pkg::REG_B2:   prdata = biq_pkg::DataW'(cfg_reg.b2);
            biq_pkg::REG_A1:   prdata = biq_pkg::DataW'(cfg_reg.a1);
            biq_pkg::REG_A2:   prdata = biq_pkg::DataW'(cfg_reg.a2);
            biq_pkg::REG_SA1:  prdata = biq_pkg::DataW'(cfg_reg.sa1);
            biq_pkg::REG_SA2:  prdata = biq_pkg::DataW'(cfg_reg.sa2);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode <= 1'b0;
            cfg_reg.b0   <= biq_pkg::B0Reset;
            cfg_reg.b1   <= biq_pkg::B1Reset;
            cfg_reg.b2   <= biq_pkg::B2Reset;
            cfg_reg.a1   <= biq_pkg::A1Reset;
            cfg_reg.a2   <= biq_pkg::A2Reset;
            cfg_reg.sa1  <= biq_pkg::SA1Reset;
            cfg_reg.sa2  <= biq_pkg::SA2Reset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> design/biq_ucode_rom.sv
// Microprogram: one control word per step of the filter sequence.
module biq_ucode_rom (
    input  biq_pkg::step_t step,
    output biq_pkg::ctrl_t ctrl
);

    always_comb
    begin
        ctrl = biq_pkg::NopCtrl;
        case (step)
            // first section: f0..f2 = b*x, exact since x has a zero fraction
            5'd0:
            begin
                ctrl.mul_en   = 1'b1;
                ctrl.coef_sel = biq_pkg::CSEL_B0;
                ctrl.opnd_sel = biq_pkg::OPND_SAMPLE;
            end
            5'd1:
            begin
                ctrl.mul_en   = 1'b1;
                ctrl.coef_sel = biq_pkg::CSEL_B1;
                ctrl.opnd_sel = biq_pkg::OPND_SAMPLE;
                ctrl.f_op     = biq_pkg::F_LD0;
            end
            5'd2:
            begin
                ctrl.mul_en   = 1'b1;
                ctrl.coef_sel = biq_pkg::CSEL_B2;
                ctrl.opnd_sel = biq_pkg::OPND_SAMPLE;
                ctrl.f_op     = biq_pkg::F_LD1;
                ctrl.alu_op   = biq_pkg::ALU_Y;
            end
            5'd3:
            begin
                ctrl.mul_en   = 1'b1;
                ctrl.coef_sel = biq_pkg::CSEL_A1;
                ctrl.opnd_sel = biq_pkg::OPND_YLO;
                ctrl.f_op     = biq_pkg::F_LD2;
            end
            5'd4:
            begin
                ctrl.mul_en   = 1'b1;
                ctrl.coef_sel = biq_pkg::CSEL_A1;
                ctrl.opnd_sel = biq_pkg::OPND_YHI;
                ctrl.acc_op   = biq_pkg::ACC_LOAD;
            end
            5'd5:
            begin
                ctrl.mul_en   = 1'b1;
                ctrl.coef_sel = biq_pkg::CSEL_A2;
                ctrl.opnd_sel = biq_pkg::OPND_YLO;
                ctrl.acc_op   = biq_pkg::ACC_ADDHI;
            end
            5'd6:
            begin
                ctrl.mul_en   = 1'b1;
                ctrl.coef_sel = biq_pkg::CSEL_A2;
                ctrl.opnd_sel = biq_pkg::OPND_YHI;
                ctrl.acc_op   = biq_pkg::ACC_LOAD;
                ctrl.alu_op   = biq_pkg::ALU_D1;
            end
            5'd7:
            begin
                ctrl.acc_op   = biq_pkg::ACC_ADDHI;
            end
            5'd8:
            begin
                ctrl.alu_op   = biq_pkg::ALU_D2;
                ctrl.f_op     = biq_pkg::F_LDY;
                ctrl.seq_op   = biq_pkg::SEQ_SKIP_SINGLE;
                ctrl.target   = biq_pkg::StepEmit;
            end
            // second section: numerator 1, -2, 1 applied to the first output
            5'd9:
            begin
                ctrl.alu_op   = biq_pkg::ALU_Y;
                ctrl.sec      = 1'b1;
            end
            5'd10:
            begin
                ctrl.mul_en   = 1'b1;
                ctrl.coef_sel = biq_pkg::CSEL_SA1;
                ctrl.opnd_sel = biq_pkg::OPND_YLO;
            end
            5'd11:
            begin
                ctrl.mul_en   = 1'b1;
                ctrl.coef_sel = biq_pkg::CSEL_SA1;
                ctrl.opnd_sel = biq_pkg::OPND_YHI;
                ctrl.acc_op   = biq_pkg::ACC_LOAD;
            end
            5'd12:
            begin
                ctrl.mul_en   = 1'b1;
                ctrl.coef_sel = biq_pkg::CSEL_SA2;
                ctrl.opnd_sel = biq_pkg::OPND_YLO;
                ctrl.acc_op   = biq_pkg::ACC_ADDHI;
            end
            5'd13:
            begin
                ctrl.mul_en   = 1'b1;
                ctrl.coef_sel = biq_pkg::CSEL_SA2;
                ctrl.opnd_sel = biq_pkg::OPND_YHI;
                ctrl.acc_op   = biq_pkg::ACC_LOAD;
                ctrl.alu_op   = biq_pkg::ALU_D1;
                ctrl.sec      = 1'b1;
            end
            5'd14:
            begin
                ctrl.acc_op   = biq_pkg::ACC_ADDHI;
            end
            5'd15:
            begin
                ctrl.alu_op   = biq_pkg::ALU_D2;
                ctrl.sec      = 1'b1;
            end
            biq_pkg::StepEmit:
            begin
                ctrl.seq_op   = biq_pkg::SEQ_EMIT;
            end
            default:
            begin
                ctrl.seq_op   = biq_pkg::SEQ_EMIT;
            end
        endcase
    end

endmodule

>>> design/biq_sequencer.sv
// Step counter, conditional jump and input/output beat handshake.
module biq_sequencer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  logic           mode,
    input  biq_pkg::ctrl_t ctrl,
    output biq_pkg::step_t step,
    output biq_pkg::seq_t  seq
);

    logic           busy_reg;
    logic           busy_next;
    biq_pkg::step_t step_reg;
    biq_pkg::step_t step_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           accept;
    logic           out_free;
    logic           emit;

    assign accept    = in_valid & ~busy_reg;
    assign out_free  = ~out_valid_reg | ~out_stall;
    assign emit      = busy_reg & (ctrl.seq_op == biq_pkg::SEQ_EMIT) & out_free;
    assign in_stall  = busy_reg;
    assign out_valid = out_valid_reg;
    assign step      = step_reg;
    assign seq.run   = busy_reg;
    assign seq.load  = accept;
    assign seq.emit  = emit;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            case (ctrl.seq_op)
                biq_pkg::SEQ_NEXT:
                    step_next = step_reg + 1'b1;
                biq_pkg::SEQ_SKIP_SINGLE:
                    step_next = mode ? step_reg + 1'b1 : ctrl.target;
                biq_pkg::SEQ_EMIT:
                    busy_next = ~out_free;
                default:
                    busy_next = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg & out_stall;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> design/biq_datapath.sv
// Shared multiplier, accumulator, section delays and output rounding.
module biq_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  biq_pkg::ctrl_t  ctrl,
    input  biq_pkg::seq_t   seq,
    input  biq_pkg::cfg_t   cfg,
    input  biq_pkg::sample_t sample_in,
    output biq_pkg::sample_t sample_out,
    output logic            clipped
);

    localparam int OutSumW = biq_pkg::DelayW + 1;
    localparam int OutRW   = OutSumW - biq_pkg::StateFrac;
    localparam int OutChkW = OutRW - biq_pkg::SampleW + 1;
    localparam int WideChk = biq_pkg::WideW - biq_pkg::DelayW + 1;

    localparam biq_pkg::acc_t AccHalf =
        biq_pkg::acc_t'(1) <<< (biq_pkg::StateFrac - 1);
    localparam logic signed [OutSumW-1:0] OutHalf =
        OutSumW'(1) <<< (biq_pkg::StateFrac - 1);
    localparam biq_pkg::sample_t SampleMax = {1'b0, {(biq_pkg::SampleW-1){1'b1}}};
    localparam biq_pkg::sample_t SampleMin = {1'b1, {(biq_pkg::SampleW-1){1'b0}}};
    localparam biq_pkg::delay_t DelayMax = {1'b0, {(biq_pkg::DelayW-1){1'b1}}};
    localparam biq_pkg::delay_t DelayMin = {1'b1, {(biq_pkg::DelayW-1){1'b0}}};

    function automatic biq_pkg::delay_t sat_delay(input biq_pkg::wide_t v);
        logic [WideChk-1:0] top;
        top = v[biq_pkg::WideW-1:biq_pkg::DelayW-1];
        if (top == {WideChk{1'b0}} || top == {WideChk{1'b1}})
            return v[biq_pkg::DelayW-1:0];
        return v[biq_pkg::WideW-1] ? DelayMin : DelayMax;
    endfunction

    biq_pkg::sample_t sample_reg, sample_next;
    biq_pkg::prod_t   p_reg, p_next;
    biq_pkg::acc_t    acc_reg, acc_next;
    biq_pkg::fval_t   f0_reg, f0_next;
    biq_pkg::fval_t   f1_reg, f1_next;
    biq_pkg::fval_t   f2_reg, f2_next;
    biq_pkg::delay_t  y_reg, y_next;
    biq_pkg::delay_t  s1d1_reg, s1d1_next;
    biq_pkg::delay_t  s1d2_reg, s1d2_next;
    biq_pkg::delay_t  s2d1_reg, s2d1_next;
    biq_pkg::delay_t  s2d2_reg, s2d2_next;
    biq_pkg::sample_t out_reg, out_next;
    logic             clip_reg, clip_next;

    biq_pkg::coef_t   coef_mux;
    biq_pkg::opnd_t   opnd_mux;
    biq_pkg::prod_t   prod;
    biq_pkg::delay_t  d1_sel;
    biq_pkg::delay_t  d2_sel;
    biq_pkg::acc_t    acc_rnd;
    biq_pkg::fval_t   prod_rnd;
    biq_pkg::wide_t   y_sum;
    biq_pkg::wide_t   n1_sum;
    biq_pkg::wide_t   n2_sum;
    biq_pkg::acc_t    hi_term;
    logic signed [OutSumW-1:0] o_sum;
    logic signed [OutRW-1:0]   o_r;
    logic [OutChkW-1:0]        o_top;

    always_comb
    begin
        case (ctrl.coef_sel)
            biq_pkg::CSEL_B0:  coef_mux = cfg.b0;
            biq_pkg::CSEL_B1:  coef_mux = cfg.b1;
            biq_pkg::CSEL_B2:  coef_mux = cfg.b2;
            biq_pkg::CSEL_A1:  coef_mux = cfg.a1;
            biq_pkg::CSEL_A2:  coef_mux = cfg.a2;
            biq_pkg::CSEL_SA1: coef_mux = cfg.sa1;
            biq_pkg::CSEL_SA2: coef_mux = cfg.sa2;
            default:           coef_mux = '0;
        endcase
    end

    // y is split as signed high part times 2^SplitW plus unsigned low part
    always_comb
    begin
        case (ctrl.opnd_sel)
            biq_pkg::OPND_SAMPLE: opnd_mux = biq_pkg::OpndW'(sample_reg);
            biq_pkg::OPND_YLO:    opnd_mux = {1'b0, y_reg[biq_pkg::SplitW-1:0]};
            biq_pkg::OPND_YHI:    opnd_mux = {y_reg[biq_pkg::DelayW-1],
                                              y_reg[biq_pkg::DelayW-1:biq_pkg::SplitW]};
            default:              opnd_mux = '0;
        endcase
    end

    assign prod    = coef_mux * opnd_mux;
    assign hi_term = {p_reg[biq_pkg::AccW-biq_pkg::SplitW-1:0], {biq_pkg::SplitW{1'b0}}};

    assign d1_sel  = ctrl.sec ? s2d1_reg : s1d1_reg;
    assign d2_sel  = ctrl.sec ? s2d2_reg : s1d2_reg;

    // round half up to StateFrac fraction bits
    assign acc_rnd  = acc_reg + AccHalf;
    assign prod_rnd = acc_rnd[biq_pkg::AccW-1:biq_pkg::StateFrac];

    assign y_sum  = biq_pkg::WideW'(f0_reg) + biq_pkg::WideW'(d1_sel);
    assign n1_sum = biq_pkg::WideW'(f1_reg) - biq_pkg::WideW'(prod_rnd)
                  + biq_pkg::WideW'(d2_sel);
    assign n2_sum = biq_pkg::WideW'(f2_reg) - biq_pkg::WideW'(prod_rnd);

    assign o_sum = OutSumW'(y_reg) + OutHalf;
    assign o_r   = o_sum[OutSumW-1:biq_pkg::StateFrac];
    assign o_top = o_r[OutRW-1:biq_pkg::SampleW-1];

    always_comb
    begin
        sample_next = sample_reg;
        p_next      = p_reg;
        acc_next    = acc_reg;
        f0_next     = f0_reg;
        f1_next     = f1_reg;
        f2_next     = f2_reg;
        y_next      = y_reg;
        s1d1_next   = s1d1_reg;
        s1d2_next   = s1d2_reg;
        s2d1_next   = s2d1_reg;
        s2d2_next   = s2d2_reg;
        out_next    = out_reg;
        clip_next   = clip_reg;

        if (seq.load)
        begin
            sample_next = sample_in;
        end

        if (seq.run)
        begin
            if (ctrl.mul_en)
            begin
                p_next = prod;
            end

            case (ctrl.acc_op)
                biq_pkg::ACC_LOAD:  acc_next = biq_pkg::AccW'(p_reg);
                biq_pkg::ACC_ADDHI: acc_next = acc_reg + hi_term;
                default:            acc_next = acc_reg;
            endcase

            case (ctrl.f_op)
                biq_pkg::F_LD0: f0_next = biq_pkg::FW'(p_reg);
                biq_pkg::F_LD1: f1_next = biq_pkg::FW'(p_reg);
                biq_pkg::F_LD2: f2_next = biq_pkg::FW'(p_reg);
                biq_pkg::F_LDY:
                begin
                    f0_next = biq_pkg::FW'(y_reg);
                    f1_next = -(biq_pkg::FW'(y_reg) <<< 1);
                    f2_next = biq_pkg::FW'(y_reg);
                end
                default: f0_next = f0_reg;
            endcase

            case (ctrl.alu_op)
                biq_pkg::ALU_Y: y_next = sat_delay(y_sum);
                biq_pkg::ALU_D1:
                begin
                    if (ctrl.sec)
                        s2d1_next = sat_delay(n1_sum);
                    else
                        s1d1_next = sat_delay(n1_sum);
                end
                biq_pkg::ALU_D2:
                begin
                    if (ctrl.sec)
                        s2d2_next = sat_delay(n2_sum);
                    else
                        s1d2_next = sat_delay(n2_sum);
                end
                default: y_next = y_reg;
            endcase
        end

        if (seq.emit)
        begin
            if (o_top == {OutChkW{1'b0}} || o_top == {OutChkW{1'b1}})
            begin
                out_next  = o_r[biq_pkg::SampleW-1:0];
                clip_next = 1'b0;
            end
            else
            begin
                out_next  = o_r[OutRW-1] ? SampleMin : SampleMax;
                clip_next = 1'b1;
            end
        end
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1d1_reg <= '0;
            s1d2_reg <= '0;
            s2d1_reg <= '0;
            s2d2_reg <= '0;
        end
        else
        begin
            s1d1_reg <= s1d1_next;
            s1d2_reg <= s1d2_next;
            s2d1_reg <= s2d1_next;
            s2d2_reg <= s2d2_next;
        end
    end

    // working registers and output beat
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        p_reg      <= p_next;
        acc_reg    <= acc_next;
        f0_reg     <= f0_next;
        f1_reg     <= f1_next;
        f2_reg     <= f2_next;
        y_reg      <= y_next;
        out_reg    <= out_next;
        clip_reg   <= clip_next;
    end

    assign sample_out = out_reg;
    assign clipped    = clip_reg;

endmodule

>>> design/cascaded_biquad_iir_filter.sv
// Fixed-point biquad IIR filter, one or two sections, microcoded top level.
//
// Input channel: in_valid/in_stall carry one signed sample_in per beat.
// Output channel: out_valid/out_stall carry sample_out and clipped.
// Coefficients and the section mode are written over the APB-style port.
// One 18x21 multiplier is shared by every product; a 17-word microprogram
// steps it, with each 40-bit delay word split into two halves whose
// products are accumulated.
// In either mode a new sample is taken only once the previous result has
// been emitted; single-section mode skips the second-section steps.
// in_stall is high while a sample is being worked on. A finished result
// sits in the output register; if the receiver still stalls the previous
// result, the sequencer holds at its last step until that slot frees up.
// Reset clears the delay state, loads the default lowpass coefficients
// and selects single-section mode.
module cascaded_biquad_iir_filter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [biq_pkg::AddrW-1:0]    paddr,
    input  logic [biq_pkg::DataW-1:0]    pwdata,
    output logic [biq_pkg::DataW-1:0]    prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [biq_pkg::SampleW-1:0] sample_in,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [biq_pkg::SampleW-1:0] sample_out,
    output logic                         clipped
);

    biq_pkg::cfg_t  cfg;
    biq_pkg::ctrl_t ctrl;
    biq_pkg::step_t step;
    biq_pkg::seq_t  seq;

    biq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    biq_ucode_rom u_rom (
        .step (step),
        .ctrl (ctrl)
    );

    biq_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .mode      (cfg.mode),
        .ctrl      (ctrl),
        .step      (step),
        .seq       (seq)
    );

    biq_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .seq        (seq),
        .cfg        (cfg),
        .sample_in  (sample_in),
        .sample_out (sample_out),
        .clipped    (clipped)
    );

endmodule
